>>> design/mpd_pkg.sv
// Shared types and constants for the modular power and divide block.
// Used by mpd_mul, mpd_rem and modular_power_and_divide; no dependencies.
package mpd_pkg;

  // Operand and exponent widths
  localparam int unsigned MOD_W    = 32;
  localparam int unsigned B_W      = 64;
  localparam int unsigned EXP_BITS = 64;
  localparam int unsigned E_W      = (EXP_BITS > MOD_W) ? EXP_BITS : MOD_W;
  localparam int unsigned PROD_W   = 2 * MOD_W;

  // Remainder unit: two quotient bits retired per cycle
  localparam int unsigned REM_BITS_PER_CYC = 2;
  localparam int unsigned REM_CYCLES       = PROD_W / REM_BITS_PER_CYC;
  localparam int unsigned REM_CNT_W        = $clog2(REM_CYCLES);

  // Register reset value
  localparam logic [MOD_W-1:0] MODULUS_RST = 32'd1000000007;

  // Function select carried on tuser
  localparam logic FUNC_POW = 1'b0;
  localparam logic FUNC_DIV = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LAUNCH,
    ST_WAIT,
    ST_OUT
  } state_e;

  // Kind of reduction currently in flight
  typedef enum logic [1:0] {
    OP_RED,
    OP_ACC,
    OP_SQ,
    OP_FIN
  } op_e;

  // Request into the remainder unit
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
  } rem_req_t;

  // Response from the remainder unit
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] remainder;
  } rem_rsp_t;

endpackage

>>> design/mpd_mul.sv
// Registered 32x32 unsigned multiplier shared by all modular products.
// Depends on mpd_pkg for widths.
module mpd_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [mpd_pkg::MOD_W-1:0]  x_i,
  input  logic [mpd_pkg::MOD_W-1:0]  y_i,
  output logic [mpd_pkg::PROD_W-1:0] prod_o
);

  logic [mpd_pkg::PROD_W-1:0] prod_q;

  // Capture the full product when enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= mpd_pkg::PROD_W'(x_i) * mpd_pkg::PROD_W'(y_i);
    end
  end

  assign prod_o = prod_q;

endmodule

>>> design/mpd_rem.sv
// Iterative remainder unit: 64-bit dividend modulo a 32-bit modulus,
// restoring division retiring two bits per cycle. Depends on mpd_pkg.
module mpd_rem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mpd_pkg::MOD_W-1:0] modulus_i,
  input  mpd_pkg::rem_req_t         req_i,
  output mpd_pkg::rem_rsp_t         rsp_o
);

  logic [mpd_pkg::PROD_W-1:0]    dvd_q, dvd_d;
  logic [mpd_pkg::MOD_W-1:0]     rem_q, rem_d;
  logic [mpd_pkg::REM_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [mpd_pkg::MOD_W-1:0]     rem_mid;

  // One restoring step: shift in a bit, subtract the modulus if it fits
  function automatic logic [mpd_pkg::MOD_W-1:0] rem_step(
    input logic [mpd_pkg::MOD_W-1:0] r,
    input logic                      din,
    input logic [mpd_pkg::MOD_W-1:0] m
  );
    logic [mpd_pkg::MOD_W:0] t;
    t = {r, din};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[mpd_pkg::MOD_W-1:0];
  endfunction

  // Advance two bits per cycle while busy
  always_comb begin
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    rem_mid = rem_step(rem_q, dvd_q[mpd_pkg::PROD_W-1], modulus_i);
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = rem_step(rem_mid, dvd_q[mpd_pkg::PROD_W-2], modulus_i);
      dvd_d = {dvd_q[mpd_pkg::PROD_W-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mpd_pkg::REM_CNT_W'(mpd_pkg::REM_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  // Reduction by zero gives zero
  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = (modulus_i == '0) ? '0 : rem_q;

endmodule

>>> design/modular_power_and_divide.sv
// Modular power (base^exp mod m) and Fermat divide (a * b^(m-2) mod m).
// Power runs one modular product per step, up to 127 products for a 64-bit exponent;
// divide first reduces the divisor, then runs its products, the final multiply by the
// numerator included.
// One item at a time: the next beat is taken in the cycle after the result beat leaves.
// Reset (async, active low) returns to idle and loads modulus 1000000007.
module modular_power_and_divide (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [mpd_pkg::MOD_W-1:0] cfg_wdata_i,   // modulus
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [95:0]               s_axis_tdata,  // [31:0] operand_a, [95:32] operand_b
  input  logic                      s_axis_tuser,  // [0] func
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata   // [31:0] result
);

  mpd_pkg::state_e state_q, state_d;
  mpd_pkg::op_e    op_q, op_d;

  logic [mpd_pkg::MOD_W-1:0]  modulus_q;
  logic                       func_q, func_d;
  logic [mpd_pkg::MOD_W-1:0]  a_q, a_d;
  logic [mpd_pkg::B_W-1:0]    b_q, b_d;
  logic [mpd_pkg::E_W-1:0]    e_q, e_d;
  logic [mpd_pkg::MOD_W-1:0]  acc_q, acc_d;
  logic [mpd_pkg::MOD_W-1:0]  sq_q, sq_d;
  logic [mpd_pkg::MOD_W-1:0]  res_q, res_d;

  logic                       in_beat;
  logic                       mul_en;
  logic [mpd_pkg::MOD_W-1:0]  mul_x, mul_y;
  logic [mpd_pkg::PROD_W-1:0] prod;
  mpd_pkg::rem_req_t          rem_req;
  mpd_pkg::rem_rsp_t          rem_rsp;

  logic [mpd_pkg::MOD_W-1:0]  in_a;
  logic [mpd_pkg::B_W-1:0]    in_b;
  logic                       mod_small;

  assign in_a      = s_axis_tdata[mpd_pkg::MOD_W-1:0];
  assign in_b      = s_axis_tdata[mpd_pkg::MOD_W +: mpd_pkg::B_W];
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign mod_small = (modulus_q < mpd_pkg::MOD_W'(2));

  // Modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= mpd_pkg::MODULUS_RST;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpd_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser == mpd_pkg::FUNC_POW) begin
            state_d = mpd_pkg::ST_CHECK;
          end else if (mod_small) begin
            state_d = mpd_pkg::ST_OUT;
          end else begin
            state_d = mpd_pkg::ST_LAUNCH;
          end
        end
      end
      mpd_pkg::ST_CHECK: begin
        if (e_q == '0 && func_q == mpd_pkg::FUNC_POW) begin
          state_d = mpd_pkg::ST_OUT;
        end else begin
          state_d = mpd_pkg::ST_LAUNCH;
        end
      end
      mpd_pkg::ST_LAUNCH: state_d = mpd_pkg::ST_WAIT;
      mpd_pkg::ST_WAIT: begin
        if (rem_rsp.done) begin
          state_d = (op_q == mpd_pkg::OP_FIN) ? mpd_pkg::ST_OUT : mpd_pkg::ST_CHECK;
        end
      end
      mpd_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          state_d = mpd_pkg::ST_IDLE;
        end
      end
      default: state_d = mpd_pkg::ST_IDLE;
    endcase
  end

  // Handshake and shared unit controls
  always_comb begin
    s_axis_tready    = (state_q == mpd_pkg::ST_IDLE);
    m_axis_tvalid    = (state_q == mpd_pkg::ST_OUT);
    mul_en           = 1'b0;
    mul_x            = sq_q;
    mul_y            = sq_q;
    rem_req.start    = (state_q == mpd_pkg::ST_LAUNCH);
    rem_req.dividend = (op_q == mpd_pkg::OP_RED) ? b_q : prod;
    case (state_q)
      mpd_pkg::ST_CHECK: begin
        mul_en = 1'b1;
        if (e_q == '0) begin
          mul_x = a_q;
          mul_y = acc_q;
        end else if (e_q[0]) begin
          mul_x = acc_q;
          mul_y = sq_q;
        end
      end
      default: ;
    endcase
  end

  // Datapath register updates
  always_comb begin
    op_d   = op_q;
    func_d = func_q;
    a_d    = a_q;
    b_d    = b_q;
    e_d    = e_q;
    acc_d  = acc_q;
    sq_d   = sq_q;
    res_d  = res_q;
    case (state_q)
      mpd_pkg::ST_IDLE: begin
        if (in_beat) begin
          func_d = s_axis_tuser;
          a_d    = in_a;
          b_d    = in_b;
          acc_d  = mpd_pkg::MOD_W'(1);
          sq_d   = in_a;
          e_d    = mpd_pkg::E_W'(in_b[mpd_pkg::EXP_BITS-1:0]);
          op_d   = mpd_pkg::OP_RED;
          res_d  = '0;
        end
      end
      mpd_pkg::ST_CHECK: begin
        if (e_q == '0) begin
          res_d = acc_q;
          op_d  = mpd_pkg::OP_FIN;
        end else if (e_q[0]) begin
          op_d = mpd_pkg::OP_ACC;
          e_d  = {e_q[mpd_pkg::E_W-1:1], 1'b0};
        end else begin
          op_d = mpd_pkg::OP_SQ;
          e_d  = {1'b0, e_q[mpd_pkg::E_W-1:1]};
        end
      end
      mpd_pkg::ST_WAIT: begin
        if (rem_rsp.done) begin
          case (op_q)
            mpd_pkg::OP_RED: begin
              sq_d  = rem_rsp.remainder;
              acc_d = mpd_pkg::MOD_W'(1);
              e_d   = mpd_pkg::E_W'(modulus_q - mpd_pkg::MOD_W'(2));
            end
            mpd_pkg::OP_ACC: acc_d = rem_rsp.remainder;
            mpd_pkg::OP_SQ:  sq_d  = rem_rsp.remainder;
            mpd_pkg::OP_FIN: res_d = rem_rsp.remainder;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpd_pkg::ST_IDLE;
      op_q    <= mpd_pkg::OP_RED;
      func_q  <= mpd_pkg::FUNC_POW;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      func_q  <= func_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    e_q   <= e_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    res_q <= res_d;
  end

  assign m_axis_tdata = res_q;

  // Shared multiplier
  mpd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .prod_o (prod)
  );

  // Shared remainder unit
  mpd_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .modulus_i (modulus_q),
    .req_i     (rem_req),
    .rsp_o     (rem_rsp)
  );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for modular_power_and_divide: streams power and divide
// operands, predicts each result with its own 64-bit arithmetic, checks every beat.
// Depends on mpd_pkg and the modular_power_and_divide RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned RESET_CYC   = 10;
  localparam int unsigned SETTLE_CYC  = 16;
  localparam longint unsigned CYC_LIMIT = 4_000_000;

  localparam logic [31:0] PRIME_1E9_7 = 32'd1000000007;
  localparam logic [31:0] PRIME_TOP   = 32'd4294967291;
  localparam logic [31:0] WORD_MAX    = 32'hFFFF_FFFF;
  localparam logic [63:0] DWORD_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [mpd_pkg::MOD_W-1:0] cfg_wdata_i;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [95:0]               s_axis_tdata;   // [31:0] operand_a, [95:32] operand_b
  logic                      s_axis_tuser;   // [0] func
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [31:0]               m_axis_tdata;   // [31:0] result

  // Local copy of the modulus register
  logic [31:0]       modulus_q;
  logic [31:0]       pending_results[$];

  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       error_count;
  int unsigned       result_count;
  int unsigned       power_count;
  int unsigned       divide_count;
  int unsigned       modulus_writes;
  longint unsigned   cycle_count;

  modular_power_and_divide dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Reduction by zero yields zero
  function automatic logic [63:0] mod_reduce(logic [63:0] x, logic [63:0] m);
    return (m != 64'd0) ? (x % m) : 64'd0;
  endfunction

  // Both factors truncated to 32 bits, so the product is exact
  function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] prod;
    prod = {32'd0, x[31:0]} * {32'd0, y[31:0]};
    return mod_reduce(prod, m);
  endfunction

  // Right-to-left square-and-multiply; zero exponent leaves the 1 unreduced
  function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq  = {32'd0, base[31:0]};
    while (e != 64'd0) begin
      if (e[0]) acc = mod_mul(acc, sq, m);
      e  = e >> 1;
      sq = mod_mul(sq, sq, m);
    end
    return acc;
  endfunction

  function automatic logic [31:0] power_or_quotient(logic fn, logic [31:0] a, logic [63:0] b);
    logic [63:0] m;
    logic [63:0] emask;
    logic [63:0] r;
    m     = {32'd0, modulus_q};
    emask = DWORD_MAX >> (64 - mpd_pkg::EXP_BITS);
    if (fn == mpd_pkg::FUNC_POW) begin
      r = mod_pow({32'd0, a}, b & emask, m);
    end else if (m < 64'd2) begin
      r = 64'd0;
    end else begin
      r = mod_mul({32'd0, a}, mod_pow(mod_reduce(b, m), m - 64'd2, m), m);
    end
    return r[31:0];
  endfunction

  // Send one beat; called and returns at a falling edge
  task automatic send_item(input logic fn, input logic [31:0] a, input logic [63:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(power_or_quotient(fn, a, b));
    if (fn == mpd_pkg::FUNC_POW) power_count++;
    else divide_count++;
    @(negedge clk_i);
    // Idle the sender with junk on the data lines
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom, $urandom};
      s_axis_tuser  <= 1'($urandom_range(1));
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Hold the sender until every pending result has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_modulus(input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    modulus_q   = value;
    modulus_writes++;
  endtask

  function automatic logic [31:0] pick_modulus();
    case ($urandom_range(7))
      0:       return PRIME_1E9_7;
      1:       return PRIME_TOP;
      2:       return 32'd998244353;
      3:       return 32'd65521;
      4:       return 32'd13;
      5:       return 32'd2;
      6:       return WORD_MAX;
      default: return $urandom | 32'd1;
    endcase
  endfunction

  function automatic logic [31:0] pick_operand_a();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return WORD_MAX;
      2:       return $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  // Mostly short exponents to keep the run bounded, with some full-width and zero ones
  function automatic logic [63:0] pick_exponent();
    int unsigned width;
    width = $urandom_range(1, 20);
    case ($urandom_range(7))
      0:       return {$urandom, $urandom};
      1:       return 64'd0;
      default: return {$urandom, $urandom} >> (64 - width);
    endcase
  endfunction

  function automatic logic [63:0] pick_divisor();
    case ($urandom_range(7))
      0:       return 64'd0;
      1:       return {32'd0, modulus_q} * 64'($urandom_range(1, 3));
      2:       return {$urandom, $urandom};
      default: return {32'd0, $urandom};
    endcase
  endfunction

  // Power corner cases at the reset modulus
  task automatic test_power_corners();
    send_item(mpd_pkg::FUNC_POW, 32'd0, 64'd0);
    send_item(mpd_pkg::FUNC_POW, WORD_MAX, 64'd0);
    send_item(mpd_pkg::FUNC_POW, WORD_MAX, DWORD_MAX);
    send_item(mpd_pkg::FUNC_POW, 32'd0, 64'd5);
    send_item(mpd_pkg::FUNC_POW, 32'd2, 64'd10);
    send_item(mpd_pkg::FUNC_POW, 32'h1234_5678, 64'd1);
    send_item(mpd_pkg::FUNC_POW, 32'd3, 64'h8000_0000_0000_0000);
  endtask

  // Divide corner cases at the reset modulus: wide divisor, multiples, zero
  task automatic test_divide_corners();
    send_item(mpd_pkg::FUNC_DIV, WORD_MAX, 64'd1);
    send_item(mpd_pkg::FUNC_DIV, 32'd0, 64'd7);
    send_item(mpd_pkg::FUNC_DIV, 32'd5, 64'd0);
    send_item(mpd_pkg::FUNC_DIV, 32'd9, {32'd0, PRIME_1E9_7});
    send_item(mpd_pkg::FUNC_DIV, 32'd9, {31'd0, PRIME_1E9_7, 1'b0});
    send_item(mpd_pkg::FUNC_DIV, WORD_MAX, DWORD_MAX);
    send_item(mpd_pkg::FUNC_DIV, 32'd1, 64'd2);
  endtask

  // Register extremes, composite modulus, and the degenerate moduli one and zero
  task automatic test_modulus_corners();
    wait_idle();
    write_modulus(32'd2);
    send_item(mpd_pkg::FUNC_POW, 32'd3, 64'd7);
    send_item(mpd_pkg::FUNC_DIV, 32'd1, 64'd1);
    wait_idle();
    write_modulus(WORD_MAX);
    send_item(mpd_pkg::FUNC_POW, 32'hFFFF_FFFE, 64'hFFFF_FFFF);
    send_item(mpd_pkg::FUNC_DIV, 32'd7, 64'd3);
    wait_idle();
    write_modulus(32'd1);
    send_item(mpd_pkg::FUNC_POW, 32'd5, 64'd0);
    send_item(mpd_pkg::FUNC_POW, 32'd5, 64'd3);
    send_item(mpd_pkg::FUNC_DIV, 32'd5, 64'd3);
    wait_idle();
    write_modulus(32'd0);
    send_item(mpd_pkg::FUNC_POW, 32'd5, 64'd0);
    send_item(mpd_pkg::FUNC_POW, 32'd5, 64'd3);
    send_item(mpd_pkg::FUNC_DIV, 32'd5, 64'd3);
    wait_idle();
  endtask

  // Random items, switching the modulus every few items once the block drains
  task automatic test_random(input int unsigned n_items, input int unsigned idle,
                             input int unsigned stall);
    logic fn;
    idle_pct  = idle;
    stall_pct = stall;
    wait_idle();
    write_modulus(pick_modulus());
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i != 0 && i % 12 == 0) begin
        wait_idle();
        write_modulus(pick_modulus());
      end
      fn = 1'($urandom_range(1));
      if (fn == mpd_pkg::FUNC_POW) send_item(fn, pick_operand_a(), pick_exponent());
      else send_item(fn, pick_operand_a(), pick_divisor());
    end
    wait_idle();
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, actual %h", $realtime, m_axis_tdata);
      end else if (pending_results[0] !== m_axis_tdata) begin
        error_count++;
        $display("%0t: result mismatch, expected %h actual %h", $realtime,
                 pending_results[0], m_axis_tdata);
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYC_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    modulus_q      = mpd_pkg::MODULUS_RST;
    idle_pct       = 0;
    stall_pct      = 0;
    error_count    = 0;
    result_count   = 0;
    power_count    = 0;
    divide_count   = 0;
    modulus_writes = 0;
    cycle_count    = 0;
    repeat (RESET_CYC) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_power_corners();
    test_divide_corners();
    test_modulus_corners();
    test_random(29, 0, 0);
    test_random(29, 88, 0);
    test_random(29, 0, 88);
    test_random(29, 20, 20);

    $display("Covered %0d power and %0d divide items, %0d results, %0d modulus writes.",
             power_count, divide_count, result_count, modulus_writes);
    $display("Phases: no idling, sender idle, receiver stall, both; moduli incl. 0, 1, 2, max.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
design/mpd_pkg.sv
design/mpd_mul.sv
design/mpd_rem.sv
design/modular_power_and_divide.sv
tb/sv/testbench.sv
